// File: rtl/core/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and control types for the signed integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

    // Fixed field widths
    localparam int IN_W   = 32;
    localparam int CHAR_W = 8;

    // Default integer width
    localparam int VALUE_BITS_DEF = 32;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

    // Shift-and-adjust conversion: binary bits taken per cycle and BCD fix-up
    localparam int          BITS_PER_STEP = 4;
    localparam logic [3:0]  BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0]  BCD_ADJ       = 4'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture a new request
        logic step;        // one shift-and-adjust step
        logic scan;        // locate the leading non-zero digit
        logic emit_sign;   // place '-' into the output register
        logic emit_digit;  // place the current digit into the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic neg;         // request is negative
        logic last_step;   // final shift-and-adjust cycle
        logic idx_zero;    // current digit is the least significant one
        logic out_free;    // output register can take a character
    } sts_t;

endpackage : sitda_pkg

`default_nettype wire

// File: rtl/core/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed integer to its decimal ASCII text, one character per
// output transfer, most significant first, with tlast on the final digit.
// ----------------------------------------------------------------------------
// Each request on the slave side carries one two's complement integer; the
// block sends '-' for a negative value followed by the decimal digits of its
// magnitude (no leading zeros, zero gives a single '0'), the last digit
// marked by m_tlast. Each request runs through the shift-and-adjust binary
// to BCD loop, four bits per cycle, then a scan for the leading digit, and
// then its characters pass one at a time through the single output register,
// which holds whenever the master side stalls. The next request is taken as
// soon as the last character has entered the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_core
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // [31:0] value
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [CHAR_W-1:0]      m_tdata,   // [7:0] character
    output logic                   m_tlast
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    sitda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Conversion and output datapath
    sitda_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule : signed_int_to_decimal_ascii_core

`default_nettype wire

// File: rtl/core/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencing state machine: accepts a request, runs the conversion,
// then steps the sign and digits out to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_ctrl
    import sitda_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                if (sts.last_step) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan   = 1'b1;
                state_next = sts.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (sts.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (sts.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (sts.idx_zero) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule : sitda_ctrl

`default_nettype wire

// File: rtl/core/sitda_datapath.sv
// ----------------------------------------------------------------------------
// sitda_datapath
// Magnitude and BCD registers with a four-bit-per-cycle shift-and-adjust
// converter, digit pointer and the output character register.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_datapath
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [IN_W-1:0]   s_tdata,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [CHAR_W-1:0]      m_tdata,
    output logic                   m_tlast
);

    localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int MAG_W = STEPS * BITS_PER_STEP;
    localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W = NDIG * 4;
    localparam int IDX_W = $clog2(NDIG);
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int EXT_W = (VALUE_BITS > IN_W) ? VALUE_BITS : IN_W;

    logic [MAG_W-1:0]  mag_reg;
    logic [MAG_W-1:0]  mag_next;
    logic [BCD_W-1:0]  bcd_reg;
    logic [BCD_W-1:0]  bcd_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              neg_reg;
    logic              neg_next;
    logic              valid_reg;
    logic              valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic              last_reg;
    logic              last_next;

    logic [EXT_W-1:0]       in_ext;
    logic [VALUE_BITS-1:0]  in_val;
    logic [VALUE_BITS-1:0]  in_mag;
    logic [BCD_W+MAG_W-1:0] work;
    logic [IDX_W-1:0]       lead;
    logic [3:0]             cur_digit;
    logic                   out_free;

    // Sign-extend the request and form its unsigned magnitude
    assign in_ext = EXT_W'($signed(s_tdata));
    assign in_val = in_ext[VALUE_BITS-1:0];
    assign in_mag = in_val[VALUE_BITS-1] ? (~in_val + 1'b1) : in_val;

    // Four shift-and-adjust passes over the BCD and binary registers
    always_comb begin
        work = {bcd_reg, mag_reg};
        for (int b = 0; b < BITS_PER_STEP; b++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (work[MAG_W + d*4 +: 4] >= BCD_ADJ_LIMIT) begin
                    work[MAG_W + d*4 +: 4] = work[MAG_W + d*4 +: 4] + BCD_ADJ;
                end
            end
            work = work << 1;
        end
    end

    // Find the most significant non-zero digit
    always_comb begin
        lead = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[i*4 +: 4] != 4'd0) begin
                lead = IDX_W'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];
    assign out_free  = !valid_reg || m_tready;

    // Next values
    always_comb begin
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (cmd.load) begin
            mag_next = MAG_W'(in_mag);
            bcd_next = '0;
            cnt_next = '0;
            neg_next = in_val[VALUE_BITS-1];
        end
        if (cmd.step) begin
            bcd_next = work[BCD_W+MAG_W-1:MAG_W];
            mag_next = work[MAG_W-1:0];
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.scan) begin
            idx_next = lead;
        end
        if (cmd.emit_sign) begin
            char_next  = CHAR_MINUS;
            last_next  = 1'b0;
            valid_next = 1'b1;
        end
        if (cmd.emit_digit) begin
            char_next  = CHAR_ZERO + CHAR_W'(cur_digit);
            last_next  = (idx_reg == '0);
            valid_next = 1'b1;
            if (idx_reg != '0) begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign sts.neg       = neg_reg;
    assign sts.last_step = (cnt_reg == CNT_W'(STEPS - 1));
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.out_free  = out_free;

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTH
    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_sign || cmd.emit_digit) |-> out_free)
        else $error("character placed into an occupied output register");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.step, cmd.scan, cmd.emit_sign, cmd.emit_digit}))
        else $error("more than one datapath command at once");

    a_load_clears_bcd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (bcd_reg == '0))
        else $error("BCD register not cleared on a new request");

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata == CHAR_MINUS && !m_tlast) ||
                      (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE)))
        else $error("output character outside sign and digit codes");
`endif

endmodule : sitda_datapath

`default_nettype wire

// File: sim/decimal_text_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_text_checker
// Watches both channels of the integer to decimal text converter, predicts
// the character string for every accepted request and compares each
// character and its end-of-number flag in order.
// ----------------------------------------------------------------------------

module decimal_text_checker
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // [31:0] value
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [CHAR_W-1:0] m_tdata,   // [7:0] character
    input  logic              m_tlast,
    output int                fail_count,
    output int                pending
);

    localparam logic [63:0] VALUE_MASK  = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam int          RADIX       = 10;
    localparam int          DIGIT_SLOTS = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    text_char_t expected_text[$];
    int         mismatches = 0;

    // Append the decimal text of one request to the expected characters
    task automatic push_decimal_text(input logic [IN_W-1:0] raw);
        logic [63:0]       word;
        logic [63:0]       mag;
        logic              neg;
        logic [CHAR_W-1:0] digits [0:DIGIT_SLOTS-1];
        int                nd;
        int                i;
        text_char_t        c;
        // The request is two's complement, so widen it with its sign
        word = 64'($signed(raw)) & VALUE_MASK;
        neg  = word[VALUE_BITS-1];
        // Magnitude as unsigned, so the most negative value survives
        mag  = neg ? ((~word + 64'd1) & VALUE_MASK) : word;
        nd   = 0;
        // Least significant digit first; zero still yields one digit
        do begin
            digits[nd] = CHAR_ZERO + CHAR_W'(mag % RADIX);
            mag        = mag / RADIX;
            nd++;
        end while (mag != 0 && nd < DIGIT_SLOTS);
        if (neg) begin
            c.character = CHAR_MINUS;
            c.last      = 1'b0;
            expected_text.push_back(c);
        end
        for (i = nd - 1; i >= 0; i--) begin
            c.character = digits[i];
            c.last      = (i == 0);
            expected_text.push_back(c);
        end
    endtask

    // Predict on each accepted request, compare on each accepted character
    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                push_decimal_text(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    $error("unexpected character: character %0d last %0b",
                           m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.character) begin
                        $error("character: expected %0d, actual %0d",
                               want.character, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b",
                               want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= expected_text.size();
    end

endmodule : decimal_text_checker

// File: sim/signed_int_to_decimal_ascii_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_tb
// Stimulus and verdict for the integer to decimal text converter.
// ----------------------------------------------------------------------------
// Sends directed corner values, then mixed random values, with random idle
// cycles on both channels, a stretch without idling, a long receiver
// hold-off that backs the converter up, and drains between phases. The
// checker beside the converter does all prediction and comparison.
// ----------------------------------------------------------------------------

module signed_int_to_decimal_ascii_core_tb;
    import sitda_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int IDLE_PCT       = 34;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_ITEMS   = 80;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;   // [31:0] value
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [CHAR_W-1:0] m_tdata;         // [7:0] character
    logic              m_tlast;

    int   fail_count;
    int   pending;
    int   cycle_count  = 0;
    logic idle_on      = 1'b1;
    logic rx_long_hold = 1'b0;

    always #2 aclk = ~aclk;

    signed_int_to_decimal_ascii_core #(
        .VALUE_BITS (VALUE_BITS_DEF)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    decimal_text_checker #(
        .VALUE_BITS (VALUE_BITS_DEF)
    ) u_text_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one request, idling first at random; valid stays up afterwards
    task automatic send_value(input logic [IN_W-1:0] v);
        if (idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom();
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the sender until every predicted character has arrived
    task automatic wait_text_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Mix of full-range, short, power-of-ten and near-extreme values
    function automatic logic [IN_W-1:0] random_value();
        logic [IN_W-1:0] v;
        int              pick;
        int              p;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            v = $urandom();
        end else if (pick < 65) begin
            v = $urandom_range(0, 999);
            if ($urandom_range(0, 1)) v = -v;
        end else if (pick < 85) begin
            p = $urandom_range(0, 9);
            v = 1;
            repeat (p) v = v * 10;
            v = v - 1 + $urandom_range(0, 2);
            if ($urandom_range(0, 1)) v = -v;
        end else if (pick < 93) begin
            v = 32'h8000_0000 + $urandom_range(0, 15);
        end else begin
            v = 32'h7FFF_FFFF - $urandom_range(0, 15);
        end
        return v;
    endfunction

    // Receiver: random idling, or a long counted hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_long_hold) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_long_hold = 1'b0;
            end else if (idle_on) begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Stimulus
    initial begin
        logic [IN_W-1:0] directed [$];
        int              i;
        directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99,
                     32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                     32'd1000000000, 32'd999999999, -32'sd999999999,
                     32'd1234567890, -32'sd1234567890, 32'h5555_5555,
                     32'hAAAA_AAAA, -32'sd5};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners
        foreach (directed[i]) send_value(directed[i]);
        wait_text_drained();

        // Long receiver hold-off while the sender keeps offering
        rx_long_hold = 1'b1;
        idle_on      = 1'b0;
        for (i = 0; i < 8; i++) send_value(random_value());
        wait_text_drained();

        // Random values with idling on both sides
        idle_on = 1'b1;
        for (i = 0; i < RANDOM_ITEMS; i++) send_value(random_value());
        wait_text_drained();

        // Random values back to back, no idling
        idle_on = 1'b0;
        for (i = 0; i < RANDOM_ITEMS; i++) send_value(random_value());
        wait_text_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule : signed_int_to_decimal_ascii_core_tb

// File: filelist.f
rtl/core/sitda_pkg.sv
rtl/core/sitda_ctrl.sv
rtl/core/sitda_datapath.sv
rtl/core/signed_int_to_decimal_ascii_core.sv
sim/decimal_text_checker.sv
sim/signed_int_to_decimal_ascii_core_tb.sv
